/* rtl/tdpt_pkg.sv */
// ----------------------------------------------------------------------------
// Trial division prime test: shared definitions
// Field widths, default parameter values, candidate class codes and the
// status bundle of the queue between the front and back ends.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  localparam int CAND_W              = 24;
  localparam int VALUE_BITS_DEFAULT  = 24;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int CLASS_W             = 2;

  localparam logic [CLASS_W-1:0] CLASS_NOT_PRIME = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_PRIME     = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_TRIAL     = 2'd2;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* rtl/tdpt_front.sv */
// ----------------------------------------------------------------------------
// Trial division prime test: front end
// Takes one candidate per transfer, masks it to the working width and sorts
// it into settled cases (below two, two or three, even) and those that need
// trial division, then passes it on to the queue.
// ----------------------------------------------------------------------------
module tdpt_front #(
  parameter int VALUE_BITS = tdpt_pkg::VALUE_BITS_DEFAULT,
  parameter int EW         = VALUE_BITS + 1 + tdpt_pkg::CLASS_W
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [tdpt_pkg::CAND_W-1:0] candidate,
  input  logic                      range_end_mark,
  input  logic                      push,
  output logic                      full,
  input  tdpt_pkg::q_status_t       q_status,
  output logic                      q_push,
  output logic [EW-1:0]             q_wdata
);

  logic                            valid;
  logic [EW-1:0]                   entry;
  logic                            accept;
  logic [VALUE_BITS-1:0]           n;
  logic [tdpt_pkg::CLASS_W-1:0]    cls;

  assign n      = VALUE_BITS'(candidate);
  assign full   = valid && q_status.full;
  assign accept = push && !full;
  assign q_push = valid && !q_status.full;
  assign q_wdata = entry;

  always_comb begin
    priority if (n < VALUE_BITS'(2)) begin
      cls = tdpt_pkg::CLASS_NOT_PRIME;
    end else if (n < VALUE_BITS'(4)) begin
      cls = tdpt_pkg::CLASS_PRIME;
    end else if (!n[0]) begin
      cls = tdpt_pkg::CLASS_NOT_PRIME;
    end else begin
      cls = tdpt_pkg::CLASS_TRIAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (q_push) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry <= {n, range_end_mark, cls};
    end
  end

endmodule

/* rtl/tdpt_queue.sv */
// ----------------------------------------------------------------------------
// Trial division prime test: decoupling queue
// A short first-in first-out store of classified candidates between the
// front and back ends.
// ----------------------------------------------------------------------------
module tdpt_queue #(
  parameter int WIDTH = tdpt_pkg::VALUE_BITS_DEFAULT + 1 + tdpt_pkg::CLASS_W,
  parameter int DEPTH = tdpt_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [WIDTH-1:0]    wdata,
  input  logic                rd_en,
  output logic [WIDTH-1:0]    rdata,
  output tdpt_pkg::q_status_t status
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);
  assign do_wr = wr_en && !status.full;
  assign do_rd = rd_en && !status.empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

/* rtl/tdpt_back.sv */
// ----------------------------------------------------------------------------
// Trial division prime test: back end
// Runs trial division over odd divisors with a one-bit-per-cycle remainder
// unit, and holds each finished result in an output register.
// ----------------------------------------------------------------------------
module tdpt_back #(
  parameter int VALUE_BITS = tdpt_pkg::VALUE_BITS_DEFAULT,
  parameter int EW         = VALUE_BITS + 1 + tdpt_pkg::CLASS_W
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tdpt_pkg::q_status_t         q_status,
  input  logic [EW-1:0]               q_rdata,
  output logic                        q_pop,
  input  logic                        pop,
  output logic                        empty,
  output logic [tdpt_pkg::CAND_W-1:0] tested_value,
  output logic                        prime_flag,
  output logic                        last_of_range
);

  localparam int DW = VALUE_BITS / 2 + 2;
  localparam int SW = 2 * DW;
  localparam int BW = $clog2(VALUE_BITS);
  localparam int CW = tdpt_pkg::CAND_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]                   state;
  logic [VALUE_BITS-1:0]        n;
  logic                         mark;
  logic [tdpt_pkg::CLASS_W-1:0] cls;
  logic [DW-1:0]                d;
  logic [SW-1:0]                sq;
  logic [DW-1:0]                rem;
  logic [BW-1:0]                bitpos;
  logic                         prime;
  logic                         out_valid;
  logic [CW-1:0]                out_value;
  logic                         out_prime;
  logic                         out_last;

  logic [DW:0]                  rem_shift;
  logic [DW:0]                  rem_sub;
  logic [DW-1:0]                rem_new;
  logic                         sq_gt;
  logic                         out_load;

  assign rem_shift = {rem, n[bitpos]};
  assign rem_sub   = rem_shift - {1'b0, d};
  assign rem_new   = (rem_shift >= {1'b0, d}) ? rem_sub[DW-1:0] : rem_shift[DW-1:0];
  assign sq_gt     = sq > SW'(n);
  assign q_pop     = (state == ST_IDLE) && !q_status.empty;
  assign out_load  = (state == ST_DONE) && (!out_valid || pop);

  assign empty         = !out_valid;
  assign tested_value  = out_value;
  assign prime_flag    = out_prime;
  assign last_of_range = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!q_status.empty) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (cls != tdpt_pkg::CLASS_TRIAL || sq_gt) begin
            state <= ST_DONE;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (bitpos == '0) begin
            state <= (rem_new == '0) ? ST_DONE : ST_CHECK;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        n    <= q_rdata[EW-1 -: VALUE_BITS];
        mark <= q_rdata[tdpt_pkg::CLASS_W];
        cls  <= q_rdata[tdpt_pkg::CLASS_W-1:0];
        d    <= DW'(3);
        sq   <= SW'(9);
      end
      ST_CHECK: begin
        rem    <= '0;
        bitpos <= BW'(VALUE_BITS - 1);
        if (cls != tdpt_pkg::CLASS_TRIAL) begin
          prime <= (cls == tdpt_pkg::CLASS_PRIME);
        end else begin
          prime <= 1'b1;
        end
      end
      ST_DIV: begin
        rem    <= rem_new;
        bitpos <= bitpos - BW'(1);
        if (bitpos == '0) begin
          if (rem_new == '0) begin
            prime <= 1'b0;
          end else begin
            d  <= d + DW'(2);
            sq <= sq + SW'({d, 2'b00}) + SW'(4);
          end
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_value <= CW'(n);
      out_prime <= prime;
      out_last  <= mark;
    end
  end

endmodule

/* rtl/trial_division_prime_test.sv */
// ----------------------------------------------------------------------------
// Trial division prime test
// Reports for each candidate whether it is prime, together with the
// candidate and its last-of-range mark.
// ----------------------------------------------------------------------------
// Candidates arrive through a queue-style push port and results leave through
// a queue-style pop port, one result per candidate and in order. Candidates
// below two, two and three, and even numbers are settled on entry; the back
// end then passes such an item from IDLE through CHECK to DONE without any
// division. An odd candidate n of four or more is divided by 3, 5, 7 and so
// on while the divisor squared does not exceed n, stopping at the first exact
// divisor. Each trial divisor passes through CHECK and then through the
// one-bit-per-cycle remainder unit in DIV. Up to QUEUE_DEPTH candidates, plus
// one in the input register, are taken while the back end is busy, and one
// finished result waits in the output register.
module trial_division_prime_test #(
  parameter int VALUE_BITS  = tdpt_pkg::VALUE_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = tdpt_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [tdpt_pkg::CAND_W-1:0] candidate,
  input  logic                        range_end_mark,
  input  logic                        push,
  output logic                        full,
  output logic [tdpt_pkg::CAND_W-1:0] tested_value,
  output logic                        prime_flag,
  output logic                        last_of_range,
  output logic                        empty,
  input  logic                        pop
);

  localparam int EW = VALUE_BITS + 1 + tdpt_pkg::CLASS_W;

  logic                q_push;
  logic [EW-1:0]       q_wdata;
  logic                q_pop;
  logic [EW-1:0]       q_rdata;
  tdpt_pkg::q_status_t q_status;

  tdpt_front #(
    .VALUE_BITS(VALUE_BITS),
    .EW        (EW)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .candidate     (candidate),
    .range_end_mark(range_end_mark),
    .push          (push),
    .full          (full),
    .q_status      (q_status),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  tdpt_queue #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr_en (q_push),
    .wdata (q_wdata),
    .rd_en (q_pop),
    .rdata (q_rdata),
    .status(q_status)
  );

  tdpt_back #(
    .VALUE_BITS(VALUE_BITS),
    .EW        (EW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .tested_value (tested_value),
    .prime_flag   (prime_flag),
    .last_of_range(last_of_range)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full)
    else $error("Transfer into a full queue.");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("Transfer out of an empty queue.");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> empty)
    else $error("A result is shown straight after reset.");

  a_prime_is_odd: assert property (@(posedge clk) disable iff (rst)
    (!empty && prime_flag) |-> (tested_value[0] || tested_value == 24'd2))
    else $error("An even number other than two is reported prime.");

endmodule

/* dv/trial_division_prime_test_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Trial division prime test: testbench
// Feeds candidates through the push port, directed corner values first and
// then runs of consecutive candidates, most closed by a last-of-range mark,
// mixed with stray values. Every result taken from the pop port is compared,
// field by field, with a primality prediction made at the time of the input
// transfer. Both ports idle in random bursts until the tail of the run.
// ----------------------------------------------------------------------------
module trial_division_prime_test_tb;

  localparam int CAND_W         = tdpt_pkg::CAND_W;
  localparam int VALUE_BITS     = tdpt_pkg::VALUE_BITS_DEFAULT;
  localparam int RANDOM_ITEMS   = 118;
  localparam int TAIL_ITEMS     = 20;
  localparam int DRAIN_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT = 250000;

  typedef struct packed {
    logic [CAND_W-1:0] value;
    logic              mark;
  } candidate_t;

  typedef struct packed {
    logic [CAND_W-1:0] value;
    logic              prime;
    logic              last;
  } outcome_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic [CAND_W-1:0] candidate = '0;
  logic              range_end_mark = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic [CAND_W-1:0] tested_value;
  logic              prime_flag;
  logic              last_of_range;
  logic              empty;
  logic              pop = 1'b0;

  candidate_t  pending_candidates[$];
  outcome_t    expected_outcomes[$];
  candidate_t  next_candidate;
  outcome_t    due;
  int unsigned send_gap = 0;
  int unsigned pop_stall = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatch_count = 0;
  logic        calm_tail = 1'b0;

  trial_division_prime_test #(
    .VALUE_BITS(VALUE_BITS)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .candidate     (candidate),
    .range_end_mark(range_end_mark),
    .push          (push),
    .full          (full),
    .tested_value  (tested_value),
    .prime_flag    (prime_flag),
    .last_of_range (last_of_range),
    .empty         (empty),
    .pop           (pop)
  );

  always #5 clk = ~clk;

  function automatic outcome_t predict_outcome(logic [CAND_W-1:0] raw, logic mark);
    longint unsigned n;
    longint unsigned d;
    outcome_t        res;
    n = 64'(raw) & ((64'd1 << VALUE_BITS) - 64'd1);
    res.value = CAND_W'(n);
    res.last  = mark;
    res.prime = (n >= 2);
    for (d = 2; res.prime && d * d <= n; d++) begin
      if (n % d == 0) res.prime = 1'b0;
    end
    return res;
  endfunction

  task automatic add_candidate(logic [CAND_W-1:0] value, logic mark);
    candidate_t item;
    item.value = value;
    item.mark  = mark;
    pending_candidates.insert(pending_candidates.size(), item);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expected_outcomes.insert(expected_outcomes.size(),
                                 predict_outcome(candidate, range_end_mark));
      end
      if (!push || !full) begin
        if (send_gap != 0) begin
          send_gap = send_gap - 1;
          push <= 1'b0;
        end else if (pending_candidates.size() == 0) begin
          push <= 1'b0;
        end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 9);
          push <= 1'b0;
        end else begin
          next_candidate = pending_candidates.pop_front();
          candidate      <= next_candidate.value;
          range_end_mark <= next_candidate.mark;
          push           <= 1'b1;
        end
      end
      calm_tail <= (pending_candidates.size() < TAIL_ITEMS);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_outcomes.size() == 0) begin
          $display("%0t: result with none expected: value %0d prime %0b last %0b",
                   $time, tested_value, prime_flag, last_of_range);
          mismatch_count++;
        end else begin
          due = expected_outcomes.pop_front();
          if (tested_value !== due.value) begin
            $display("%0t: tested_value expected %0d actual %0d",
                     $time, due.value, tested_value);
            mismatch_count++;
          end
          if (prime_flag !== due.prime) begin
            $display("%0t: prime_flag for %0d expected %0b actual %0b",
                     $time, due.value, due.prime, prime_flag);
            mismatch_count++;
          end
          if (last_of_range !== due.last) begin
            $display("%0t: last_of_range for %0d expected %0b actual %0b",
                     $time, due.value, due.last, last_of_range);
            mismatch_count++;
          end
        end
      end
      if (pop_stall != 0) begin
        pop_stall = pop_stall - 1;
        pop <= 1'b0;
      end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
        pop_stall = $urandom_range(0, 9);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with no transfer for %0d cycles",
               $time, quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned random_count;
    int unsigned span;
    int unsigned base;
    int unsigned pick;
    logic        broken;

    add_candidate(24'd0, 1'b0);
    add_candidate(24'd1, 1'b0);
    add_candidate(24'd2, 1'b0);
    add_candidate(24'd3, 1'b1);
    add_candidate(24'd4, 1'b0);
    add_candidate(24'd5, 1'b0);
    add_candidate(24'd9, 1'b0);
    add_candidate(24'd15, 1'b0);
    add_candidate(24'd25, 1'b0);
    add_candidate(24'd49, 1'b1);
    add_candidate(24'd97, 1'b0);
    add_candidate(24'd121, 1'b1);
    add_candidate(24'd65521, 1'b0);
    add_candidate(24'd65537, 1'b1);
    add_candidate(24'h555555, 1'b0);
    add_candidate(24'hAAAAAA, 1'b1);
    add_candidate(24'h800000, 1'b0);
    add_candidate(24'h800001, 1'b0);
    add_candidate(24'd16752649, 1'b0);
    add_candidate(24'd16777213, 1'b0);
    add_candidate(24'd16777214, 1'b0);
    add_candidate(24'hFFFFFF, 1'b1);

    // Mostly whole ranges of consecutive candidates; now and then a stray
    // value or a range whose closing mark is missing.
    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        add_candidate(CAND_W'($urandom()), 1'($urandom_range(0, 1)));
        random_count++;
      end else begin
        span   = $urandom_range(1, 12);
        pick   = $urandom_range(0, 19);
        broken = ($urandom_range(0, 9) == 0);
        if (pick < 15) base = $urandom_range(0, 4095);
        else if (pick < 19) base = $urandom_range(0, 65535);
        else base = $urandom_range(0, 24'hFFFFFF - 12);
        for (int unsigned i = 0; i < span; i++) begin
          add_candidate(CAND_W'(base + i), (i == span - 1) && !broken);
        end
        random_count += span;
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_candidates.size() != 0 || push) @(negedge clk);
    while (expected_outcomes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/tdpt_pkg.sv
rtl/tdpt_front.sv
rtl/tdpt_queue.sv
rtl/tdpt_back.sv
rtl/trial_division_prime_test.sv
dv/trial_division_prime_test_tb.sv
